### rtl/box_non_max_suppression_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the box non-maximum suppression core
// Shared concurrent assertion forms, clocked on clk_i and reset by rst_ni.
// ----------------------------------------------------------------------------
`ifndef BOX_NON_MAX_SUPPRESSION_CORE_MACROS_SVH
`define BOX_NON_MAX_SUPPRESSION_CORE_MACROS_SVH

// Same-cycle implication.
`define BNMS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bnms: same-cycle check failed");

// Next-cycle implication.
`define BNMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bnms: next-cycle check failed");

`endif

### rtl/bnms_pkg.sv
// ----------------------------------------------------------------------------
// Box non-maximum suppression package
// Shared constants, box type and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package bnms_pkg;

  localparam int unsigned MaxBoxesDef = 64;
  localparam int unsigned CoordW      = 20;
  localparam int unsigned ScoreW      = 16;
  localparam logic [15:0] ThrReset    = 16'd26214;
  localparam logic [2:0]  AddrThr     = 3'd0;

  typedef struct packed {
    logic signed [CoordW-1:0] left;
    logic signed [CoordW-1:0] top;
    logic signed [CoordW-1:0] right;
    logic signed [CoordW-1:0] bottom;
    logic [ScoreW-1:0]        score;
  } box_t;

  typedef struct packed {
    logic load;
    logic pass_start;
    logic cmp_off;
    logic scan_step;
    logic take_best;
    logic emit_load;
    logic set_clear;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic pipe_busy;
    logic best_found;
  } sts_t;

endpackage

### rtl/bnms_dp.sv
// ----------------------------------------------------------------------------
// Box non-maximum suppression datapath
// Box memory, suppression marks, overlap pipeline and best-candidate tracking.
// ----------------------------------------------------------------------------
module bnms_dp #(
  parameter int unsigned MAX_BOXES = bnms_pkg::MaxBoxesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bnms_pkg::cmd_t      cmd_i,
  output bnms_pkg::sts_t      sts_o,
  input  bnms_pkg::box_t      in_box_i,
  input  logic [15:0]         thr_i,
  output bnms_pkg::box_t      out_box_o,
  output logic                out_final_o,
  output logic                out_ovf_o
);

  localparam int unsigned IdxW = $clog2(MAX_BOXES);
  localparam int unsigned CntW = $clog2(MAX_BOXES + 1);

  function automatic logic [20:0] span(input logic signed [19:0] lo,
                                       input logic signed [19:0] hi);
    logic signed [21:0] d;
    d = 22'(hi) - 22'(lo) + 22'sd16;
    return (d > 22'sd0) ? d[20:0] : 21'd0;
  endfunction

  bnms_pkg::box_t mem_q [MAX_BOXES];

  logic [CntW-1:0]      count_q;
  logic                 ovf_q;
  logic [MAX_BOXES-1:0] done_q, done_d;
  logic [IdxW-1:0]      addr_q;
  logic                 cmp_en_q;
  bnms_pkg::box_t       k_q;

  // Stage 0: memory read.
  bnms_pkg::box_t rd_q;
  logic           p0_v_q;
  logic [IdxW-1:0] p0_idx_q;

  // Stage 1: spans.
  logic            p1_v_q;
  logic [IdxW-1:0] p1_idx_q;
  bnms_pkg::box_t  p1_box_q;
  logic [20:0]     wa_q, ha_q, wb_q, hb_q, wi_q, hi_q;

  // Stage 2: areas.
  logic            p2_v_q;
  logic [IdxW-1:0] p2_idx_q;
  bnms_pkg::box_t  p2_box_q;
  logic [41:0]     area_a_q, area_b_q, inter_q;

  // Stage 3: cross-multiplied terms.
  logic            p3_v_q;
  logic [IdxW-1:0] p3_idx_q;
  bnms_pkg::box_t  p3_box_q;
  logic [57:0]     inter_sh_q;
  logic [58:0]     prod_q;

  logic            best_found_q;
  bnms_pkg::box_t  best_q;
  logic [IdxW-1:0] best_idx_q;

  bnms_pkg::box_t    out_box_q;
  logic              out_final_q, out_ovf_q;

  logic signed [19:0] il, it, ir, ib;
  logic [42:0]        uni;
  logic               sup;

  assign il  = (k_q.left > rd_q.left)     ? k_q.left   : rd_q.left;
  assign it  = (k_q.top > rd_q.top)       ? k_q.top    : rd_q.top;
  assign ir  = (k_q.right < rd_q.right)   ? k_q.right  : rd_q.right;
  assign ib  = (k_q.bottom < rd_q.bottom) ? k_q.bottom : rd_q.bottom;
  assign uni = 43'(area_a_q) + 43'(area_b_q) - 43'(inter_q);
  assign sup = cmp_en_q && ({1'b0, inter_sh_q} > prod_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (count_q < CntW'(MAX_BOXES))) begin
      mem_q[count_q[IdxW-1:0]] <= in_box_i;
    end
    if (cmd_i.scan_step) begin
      rd_q <= mem_q[addr_q];
    end
  end

  always_comb begin
    done_d = done_q;
    if (cmd_i.set_clear) begin
      done_d = '0;
    end else begin
      if (p3_v_q && sup) begin
        done_d[p3_idx_q] = 1'b1;
      end
      if (cmd_i.take_best) begin
        done_d[best_idx_q] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      ovf_q        <= 1'b0;
      done_q       <= '0;
      addr_q       <= '0;
      cmp_en_q     <= 1'b0;
      p0_v_q       <= 1'b0;
      p1_v_q       <= 1'b0;
      p2_v_q       <= 1'b0;
      p3_v_q       <= 1'b0;
      best_found_q <= 1'b0;
    end else begin
      done_q <= done_d;
      if (cmd_i.set_clear) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else if (cmd_i.load) begin
        if (count_q < CntW'(MAX_BOXES)) begin
          count_q <= count_q + CntW'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.pass_start) begin
        addr_q <= '0;
      end else if (cmd_i.scan_step) begin
        addr_q <= addr_q + IdxW'(1);
      end
      if (cmd_i.cmp_off) begin
        cmp_en_q <= 1'b0;
      end else if (cmd_i.take_best) begin
        cmp_en_q <= 1'b1;
      end
      p0_v_q <= cmd_i.scan_step && !done_q[addr_q];
      p1_v_q <= p0_v_q;
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
      if (cmd_i.pass_start) begin
        best_found_q <= 1'b0;
      end else if (p3_v_q && !sup && (!best_found_q || (p3_box_q.score > best_q.score))) begin
        best_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p0_idx_q <= addr_q;
    p1_idx_q <= p0_idx_q;
    p1_box_q <= rd_q;
    wa_q     <= span(k_q.left, k_q.right);
    ha_q     <= span(k_q.top, k_q.bottom);
    wb_q     <= span(rd_q.left, rd_q.right);
    hb_q     <= span(rd_q.top, rd_q.bottom);
    wi_q     <= span(il, ir);
    hi_q     <= span(it, ib);
    p2_idx_q <= p1_idx_q;
    p2_box_q <= p1_box_q;
    area_a_q <= wa_q * ha_q;
    area_b_q <= wb_q * hb_q;
    inter_q  <= wi_q * hi_q;
    p3_idx_q   <= p2_idx_q;
    p3_box_q   <= p2_box_q;
    inter_sh_q <= {inter_q, 16'd0};
    prod_q     <= 59'(thr_i) * 59'(uni);
    // Strict compare keeps the earliest box among equal scores.
    if (p3_v_q && !sup && (!best_found_q || (p3_box_q.score > best_q.score))) begin
      best_q     <= p3_box_q;
      best_idx_q <= p3_idx_q;
    end
    if (cmd_i.take_best) begin
      k_q <= best_q;
    end
    if (cmd_i.emit_load) begin
      out_box_q   <= k_q;
      out_final_q <= !best_found_q;
      out_ovf_q   <= ovf_q;
    end
  end

  assign sts_o.scan_last  = ((CntW'(addr_q) + CntW'(1)) == count_q);
  assign sts_o.pipe_busy  = p0_v_q | p1_v_q | p2_v_q | p3_v_q;
  assign sts_o.best_found = best_found_q;
  assign out_box_o        = out_box_q;
  assign out_final_o      = out_final_q;
  assign out_ovf_o        = out_ovf_q;

endmodule

### rtl/bnms_ctrl.sv
// ----------------------------------------------------------------------------
// Box non-maximum suppression controller
// Sequences loading, suppression passes and result delivery.
// ----------------------------------------------------------------------------
module bnms_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_set_end_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  bnms_pkg::sts_t sts_i,
  output bnms_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   first_q, first_d;

  always_comb begin
    state_d = state_q;
    first_d = first_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_LOAD: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_set_end_i) begin
            cmd_o.pass_start = 1'b1;
            cmd_o.cmp_off    = 1'b1;
            first_d          = 1'b1;
            state_d          = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          if (first_q) begin
            // The ranking pass only finds the top box; suppression starts now.
            cmd_o.take_best  = 1'b1;
            cmd_o.pass_start = 1'b1;
            first_d          = 1'b0;
            state_d          = ST_SCAN;
          end else begin
            cmd_o.emit_load = 1'b1;
            state_d         = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (!out_stall_i) begin
          if (sts_i.best_found) begin
            cmd_o.take_best  = 1'b1;
            cmd_o.pass_start = 1'b1;
            state_d          = ST_SCAN;
          end else begin
            cmd_o.set_clear = 1'b1;
            state_d         = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
    end
  end

  assign in_stall_o  = (state_q != ST_LOAD);
  assign out_valid_o = (state_q == ST_EMIT);

endmodule

### rtl/box_non_max_suppression_core.sv
// ----------------------------------------------------------------------------
// Box non-maximum suppression core
// Greedy score-ordered suppression of scored boxes with an IoU threshold.
// ----------------------------------------------------------------------------
// Boxes are taken one per cycle and stored until the box marked set_end.
// The set is then processed in passes over the n stored boxes, one memory
// read per cycle through a four-stage overlap pipeline: a first pass finds the
// top-scoring box, and each later pass suppresses boxes overlapping the current
// kept box and finds the next one. Inputs are stalled from set_end until the last
// kept box is delivered.
module box_non_max_suppression_core #(
  parameter int unsigned MAX_BOXES = bnms_pkg::MaxBoxesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [19:0] left_edge_i,
  input  logic signed [19:0] top_edge_i,
  input  logic signed [19:0] right_edge_i,
  input  logic signed [19:0] bottom_edge_i,
  input  logic [15:0]        confidence_i,
  input  logic               set_end_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [19:0] kept_left_o,
  output logic signed [19:0] kept_top_o,
  output logic signed [19:0] kept_right_o,
  output logic signed [19:0] kept_bottom_o,
  output logic [15:0]        kept_confidence_o,
  output logic               final_kept_o,
  output logic               capacity_exceeded_o
);

  logic [15:0]    thr_q;
  bnms_pkg::cmd_t cmd;
  bnms_pkg::sts_t sts;
  bnms_pkg::box_t in_box, out_box;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= bnms_pkg::ThrReset;
    end else if (psel && penable && pwrite && (paddr == bnms_pkg::AddrThr)) begin
      thr_q <= pwdata[15:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == bnms_pkg::AddrThr) ? {16'd0, thr_q} : 32'd0;

  assign in_box.left   = left_edge_i;
  assign in_box.top    = top_edge_i;
  assign in_box.right  = right_edge_i;
  assign in_box.bottom = bottom_edge_i;
  assign in_box.score  = confidence_i;

  bnms_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_set_end_i (set_end_i),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  bnms_dp #(
    .MAX_BOXES (MAX_BOXES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_box_i    (in_box),
    .thr_i       (thr_q),
    .out_box_o   (out_box),
    .out_final_o (final_kept_o),
    .out_ovf_o   (capacity_exceeded_o)
  );

  assign kept_left_o       = out_box.left;
  assign kept_top_o        = out_box.top;
  assign kept_right_o      = out_box.right;
  assign kept_bottom_o     = out_box.bottom;
  assign kept_confidence_o = out_box.score;

`include "box_non_max_suppression_core_macros.svh"

  // No new box is taken while a kept box waits for delivery.
  `BNMS_ASSERT_SAME(a_no_load_while_emit, out_valid_o, in_stall_o)
  // After a non-final result is taken the set is still being processed.
  `BNMS_ASSERT_NEXT(a_set_continues, out_valid_o && !out_stall_i && !final_kept_o, in_stall_o)
  // A closing box always starts processing, so the input stalls next cycle.
  `BNMS_ASSERT_NEXT(a_close_stalls, in_valid_i && !in_stall_o && set_end_i, in_stall_o)

endmodule
